### design/positional_ordered_list_defines.svh
// Assertion macros shared by the ordered list RTL.
// Included by the top level; needs nothing else.
`ifndef POSITIONAL_ORDERED_LIST_DEFINES_SVH
`define POSITIONAL_ORDERED_LIST_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PLC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ordered list check failed");

// next-cycle implication, disabled in reset
`define PLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ordered list check failed");

`endif

### design/plc_pkg.sv
// Shared types and constants of the ordered list block.
// No dependencies; imported by plc_cell and positional_ordered_list.
`default_nettype none

package plc_pkg;

    localparam int CAPACITY  = 16;
    localparam int POS_W     = 8;
    localparam int DATA_W    = 32;
    localparam int LEN_W     = 5;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CMP_W     = (POS_W > CNT_W) ? POS_W : CNT_W;
    localparam int S_TDATA_W = ((POS_W + DATA_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((LEN_W + DATA_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BEYOND = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_DELETE = 1'b1
    } kind_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic              insert;
        logic              remove;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] value;
    } cell_cmd_t;

endpackage

`default_nettype wire

### design/plc_cell.sv
// One slot of the ordered list chain: holds one entry, shifts from a neighbor.
// Depends on plc_pkg.
`default_nettype none

module plc_cell
    import plc_pkg::*;
(
    input  wire logic              clk,
    input  wire cell_cmd_t         cmd,
    input  wire logic [IDX_W-1:0]  index,
    input  wire logic [DATA_W-1:0] left_data,
    input  wire logic [DATA_W-1:0] right_data,
    output logic [DATA_W-1:0]      data,
    output logic [DATA_W-1:0]      hit_data
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.insert)
        begin
            if (index == cmd.idx)
                data_next = cmd.value;
            else if (index > cmd.idx)
                data_next = left_data;
        end
        else if (cmd.remove && index >= cmd.idx)
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign hit_data = (cmd.remove && index == cmd.idx) ? data_reg : '0;

endmodule

`default_nettype wire

### design/positional_ordered_list.sv
// Ordered list of signed 32-bit values held in a chain of shift cells.
// Depends on plc_pkg, plc_cell and positional_ordered_list_defines.svh.
`default_nettype none
`include "positional_ordered_list_defines.svh"

// Each request inserts a value at a 1-based position or deletes the entry at a
// position; position 0 acts as position 1 and an insert past the end appends.
// Every request gives one result: status, length after, and the removed value
// (zero unless a delete succeeded). One request is taken per cycle while s_tready
// is high; the result appears in the output register the cycle after acceptance.
// The whole update is a single step because every cell compares its own index
// with the position and loads from its left or right neighbor in parallel. The
// output register lets a new request in while a result waits, as long as that
// result is taken at the same edge.

module positional_ordered_list
    import plc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // position, value
    input  wire logic [0:0]           s_tuser,  // kind
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,  // length_after, removed_value, zero pad
    output logic [1:0]                m_tuser   // status
);

    logic                accept;
    kind_t               kind;
    logic [POS_W-1:0]    position;
    logic [DATA_W-1:0]   value;
    logic [CMP_W-1:0]    idx_raw;
    logic [CMP_W-1:0]    ins_idx;
    logic [CMP_W-1:0]    cnt_ext;
    cell_cmd_t           cmd;
    status_t             status;
    logic [DATA_W-1:0]   removed;

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                m_valid_reg;
    logic                m_valid_next;
    status_t             status_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [DATA_W-1:0]   removed_reg;

    logic [DATA_W-1:0]   cell_data [CAPACITY];
    logic [DATA_W-1:0]   cell_hit  [CAPACITY];

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign kind     = kind_t'(s_tuser[0]);
    assign position = s_tdata[POS_W-1:0];
    assign value    = s_tdata[POS_W+DATA_W-1:POS_W];

    // position 0 counts as position 1
    assign idx_raw  = (position == '0) ? '0 : CMP_W'(position) - CMP_W'(1);
    assign cnt_ext  = CMP_W'(count_reg);
    assign ins_idx  = (idx_raw > cnt_ext) ? cnt_ext : idx_raw;

    always_comb
    begin
        cmd        = '0;
        cmd.value  = value;
        status     = ST_DONE;
        count_next = count_reg;
        if (accept)
        begin
            if (kind == KIND_INSERT)
            begin
                if (count_reg >= CNT_W'(CAPACITY))
                begin
                    status = ST_FULL;
                end
                else
                begin
                    cmd.insert = 1'b1;
                    cmd.idx    = IDX_W'(ins_idx);
                    count_next = CNT_W'(count_reg + 1'b1);
                end
            end
            else
            begin
                if (count_reg == '0)
                begin
                    status = ST_EMPTY;
                end
                else if (idx_raw >= cnt_ext)
                begin
                    status = ST_BEYOND;
                end
                else
                begin
                    cmd.remove = 1'b1;
                    cmd.idx    = IDX_W'(idx_raw);
                    count_next = CNT_W'(count_reg - 1'b1);
                end
            end
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] left_in;
        logic [DATA_W-1:0] right_in;

        if (i == 0)
        begin : g_first
            assign left_in = cmd.value;
        end
        else
        begin : g_mid_l
            assign left_in = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_in = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_in = cell_data[i+1];
        end

        plc_cell u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .index      (IDX_W'(i)),
            .left_data  (left_in),
            .right_data (right_in),
            .data       (cell_data[i]),
            .hit_data   (cell_hit[i])
        );
    end

    // at most one cell reports a hit
    always_comb
    begin
        removed = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            removed = removed | cell_hit[i];
        end
    end

    always_comb
    begin
        if (accept)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg  <= status;
            len_reg     <= LEN_W'(count_next);
            removed_reg <= removed;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({removed_reg, len_reg});
    assign m_tuser  = status_reg;

    `PLC_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `PLC_ASSERT_NEXT(a_insert_grows, clk, rst_n,
        accept && kind == KIND_INSERT && count_reg < CNT_W'(CAPACITY),
        count_reg == CNT_W'($past(count_reg) + 1'b1))
    `PLC_ASSERT_NEXT(a_len_matches, clk, rst_n, accept,
        m_valid_reg && len_reg == LEN_W'(count_reg))
    `PLC_ASSERT_NOW(a_removed_zero, clk, rst_n,
        m_valid_reg && status_reg != ST_DONE, removed_reg == '0)

endmodule

`default_nettype wire

### test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of positional_ordered_list: directed and random requests,
// each result predicted by an in-bench ordered list and checked in order.
// Depends on plc_pkg and the positional_ordered_list RTL.

module tb;
    import plc_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 60;

    typedef struct {
        status_t           status;
        logic [LEN_W-1:0]  length_after;
        logic [DATA_W-1:0] removed_value;
    } list_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [0:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;

    // in-bench copy of the list
    logic [DATA_W-1:0] list_mem [CAPACITY];
    int unsigned       list_len = 0;

    list_result_t pending_results[$];
    int unsigned  failures = 0;
    bit           calm = 1'b0;
    bit           hold_req = 1'b0;

    positional_ordered_list u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic list_result_t apply_request(kind_t k, logic [POS_W-1:0] pos,
                                                   logic [DATA_W-1:0] val);
        list_result_t r;
        int unsigned  idx;
        int unsigned  i;
        r.status = ST_DONE;
        r.removed_value = '0;
        idx = (pos == 0) ? 0 : pos - 1;
        if (k == KIND_INSERT)
        begin
            if (list_len >= CAPACITY)
                r.status = ST_FULL;
            else
            begin
                if (idx > list_len)
                    idx = list_len;
                for (i = list_len; i > idx; i--)
                    list_mem[i] = list_mem[i - 1];
                list_mem[idx] = val;
                list_len++;
            end
        end
        else if (list_len == 0)
            r.status = ST_EMPTY;
        else if (idx >= list_len)
            r.status = ST_BEYOND;
        else
        begin
            r.removed_value = list_mem[idx];
            for (i = idx; i + 1 < list_len; i++)
                list_mem[i] = list_mem[i + 1];
            list_len--;
        end
        r.length_after = list_len[LEN_W-1:0];
        return r;
    endfunction

    // valid stays high between back-to-back requests; lowered on an idle gap or while waiting for all results
    task automatic send_request(kind_t k, logic [POS_W-1:0] pos, logic [DATA_W-1:0] val);
        int unsigned gap;
        if (!calm && $urandom_range(99) < 8)
        begin
            gap = $urandom_range(3, 1);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {val, pos};
        s_tuser  <= k;
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(apply_request(k, pos, val));
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic test_directed_cases();
        int unsigned i;
        send_request(KIND_DELETE, 8'd1, 32'h0);           // empty store
        send_request(KIND_INSERT, 8'd0, 32'h8000_0000);   // position zero acts as 1
        send_request(KIND_INSERT, 8'd255, 32'h7fff_ffff); // past end appends
        send_request(KIND_INSERT, 8'd1, 32'hffff_ffff);   // start
        send_request(KIND_DELETE, 8'd200, 32'h1234_5678); // beyond length
        send_request(KIND_DELETE, 8'd3, 32'h0);           // end
        send_request(KIND_DELETE, 8'd0, 32'h0);           // start via position zero
        send_request(KIND_DELETE, 8'd1, 32'h0);           // last element leaves
        for (i = 0; i < CAPACITY; i++)
            send_request(KIND_INSERT, (i % 2 != 0) ? 8'd1 : 8'd128,
                         (32'h1 << i) ^ 32'ha5a5_0000);
        send_request(KIND_INSERT, 8'd4, 32'hdead_beef);   // full, refused
        send_request(KIND_DELETE, 8'd16, 32'h0);          // end of a full list
    endtask

    task automatic test_random_traffic(int unsigned n_items);
        int unsigned      i;
        int unsigned      delete_pct;
        kind_t            k;
        logic [POS_W-1:0] pos;
        delete_pct = 50;
        for (i = 0; i < n_items; i++)
        begin
            // drift toward full or empty; the delete share is re-drawn every 48 requests
            if (i % 48 == 0)
                delete_pct = $urandom_range(85, 15);
            k = ($urandom_range(99) < delete_pct) ? KIND_DELETE : KIND_INSERT;
            if ($urandom_range(3) == 0)
                pos = POS_W'($urandom_range(255));
            else
                pos = POS_W'($urandom_range(list_len + 1));
            send_request(k, pos, $urandom);
        end
    endtask

    task automatic test_calm_stretch();
        calm = 1'b1;
        test_random_traffic(150);
        calm = 1'b0;
    endtask

    task automatic test_output_hold();
        hold_req = 1'b1;
        test_random_traffic(30);
    endtask

    task automatic test_pause_and_resume();
        wait_all_results();
        test_random_traffic(40);
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                repeat (HOLD_CYCLES)
                begin
                    m_tready <= 1'b0;
                    @(posedge clk);
                end
            end
            m_tready <= calm || ($urandom_range(99) >= 8);
        end
    end

    always @(posedge clk)
    begin
        list_result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding");
                failures++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (m_tuser !== exp_r.status)
                begin
                    $error("status: expected %0d, got %0d", exp_r.status, m_tuser);
                    failures++;
                end
                if (m_tdata[LEN_W-1:0] !== exp_r.length_after)
                begin
                    $error("length_after: expected %0d, got %0d",
                           exp_r.length_after, m_tdata[LEN_W-1:0]);
                    failures++;
                end
                if (m_tdata[LEN_W+DATA_W-1:LEN_W] !== exp_r.removed_value)
                begin
                    $error("removed_value: expected %0d, got %0d",
                           $signed(exp_r.removed_value),
                           $signed(m_tdata[LEN_W+DATA_W-1:LEN_W]));
                    failures++;
                end
                if (m_tdata[M_TDATA_W-1:LEN_W+DATA_W] !== '0)
                begin
                    $error("pad: expected 0, got %0h", m_tdata[M_TDATA_W-1:LEN_W+DATA_W]);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        int unsigned quiet_cycles;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles == IDLE_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        wait_all_results();
        test_random_traffic(300);
        test_calm_stretch();
        test_output_hold();
        test_pause_and_resume();
        test_random_traffic(360);
        wait_all_results();
        repeat (4) @(posedge clk);
        if (failures == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/plc_pkg.sv
design/plc_cell.sv
design/positional_ordered_list.sv
test/tb.sv
